// ===== hdl/affine_cipher_mod26_assert.svh =====
// Assertion macros shared by the affine cipher RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef AFFINE_CIPHER_MOD26_ASSERT_SVH
`define AFFINE_CIPHER_MOD26_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acm assertion failed");

`endif

// ===== hdl/acm_pkg.sv =====
// Package for the affine cipher: item types, microcode word, control ROM and mod 26 helper.
// Used by acm_seq, affine_cipher_mod26 and the testbench; depends on nothing else.
package acm_pkg;

	localparam int unsigned ALPHA = 26;
	localparam logic [7:0] LETTER_A = 8'd65;
	localparam logic [4:0] KEY_MULT_RESET = 5'd17;
	localparam logic [4:0] KEY_ADD_RESET = 5'd20;
	localparam logic REG_KEY_MULT = 1'b0;
	localparam logic REG_KEY_ADD = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [7:0] in_char;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic key_error;
	} out_t;

	typedef logic [2:0] pc_t;

	localparam pc_t PC_FETCH = 3'd0;
	localparam pc_t PC_EINIT = 3'd1;
	localparam pc_t PC_ESUB = 3'd2;
	localparam pc_t PC_ESWAP = 3'd3;
	localparam pc_t PC_EDONE = 3'd4;
	localparam pc_t PC_DMUL = 3'd5;
	localparam pc_t PC_EMIT = 3'd6;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_NO_IN,
		HOLD_OUT_BUSY
	} hold_t;

	typedef enum logic [2:0] {
		J_NEVER,
		J_ALWAYS,
		J_NEED_INV,
		J_A_ZERO,
		J_SUB_GE,
		J_RPREV_NZ
	} jcond_t;

	typedef struct packed {
		hold_t hold;
		jcond_t jc;
		pc_t jmp;
		pc_t nxt;
		logic ld_item;
		logic ld_acc;
		logic euc_init;
		logic euc_sub;
		logic euc_swap;
		logic inv_wr;
		logic ld_out;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic need_inv;
		logic a_zero;
		logic sub_ge;
		logic rprev_nz;
	} stat_t;

	function automatic ctl_t acm_rom(input pc_t pc);
		ctl_t w;
		w = '{hold: HOLD_NONE, jc: J_NEVER, jmp: PC_FETCH, nxt: PC_FETCH, default: 1'b0};
		case (pc)
			PC_FETCH: begin
				w.hold = HOLD_NO_IN;
				w.jc = J_NEED_INV;
				w.jmp = PC_EINIT;
				w.nxt = PC_EMIT;
				w.ld_item = 1'b1;
				w.ld_acc = 1'b1;
			end
			PC_EINIT: begin
				w.jc = J_A_ZERO;
				w.jmp = PC_EDONE;
				w.nxt = PC_ESUB;
				w.euc_init = 1'b1;
			end
			PC_ESUB: begin
				w.jc = J_SUB_GE;
				w.jmp = PC_ESUB;
				w.nxt = PC_ESWAP;
				w.euc_sub = 1'b1;
			end
			PC_ESWAP: begin
				w.jc = J_RPREV_NZ;
				w.jmp = PC_ESUB;
				w.nxt = PC_EDONE;
				w.euc_swap = 1'b1;
			end
			PC_EDONE: begin
				w.nxt = PC_DMUL;
				w.inv_wr = 1'b1;
			end
			PC_DMUL: begin
				w.nxt = PC_EMIT;
				w.ld_acc = 1'b1;
			end
			PC_EMIT: begin
				w.hold = HOLD_OUT_BUSY;
				w.nxt = PC_FETCH;
				w.ld_out = 1'b1;
			end
			default: begin
				w.nxt = PC_FETCH;
			end
		endcase
		return w;
	endfunction

	// Remainder mod 26 of a value below 1024, by reciprocal multiply and one correction.
	function automatic logic [4:0] acm_mod26(input logic [9:0] v);
		logic [18:0] p;
		logic [9:0] q;
		logic [10:0] r;
		p = 19'(v) * 19'd315;
		q = 10'(p >> 13);
		r = 11'(v) - 11'(11'(q) * 11'(ALPHA));
		if (r >= 11'(ALPHA)) begin
			r = r - 11'(ALPHA);
		end
		return 5'(r);
	endfunction

endpackage

// ===== hdl/affine_cipher_mod26.sv =====
// Affine cipher over A..Z, mod 26. Each input item carries a command (encrypt or decrypt) and one
// character and yields one output item. Encrypts, and decrypts once the key inverse is known, go
// through FETCH, which accepts the item and multiplies, and EMIT, which reduces and emits. The first decrypt after
// reset or a key write runs the extended Euclidean algorithm by repeated subtraction in the
// microcoded datapath before its multiply. Non-letters pass unchanged;
// a key with no inverse flags key_error on decrypt and passes the character.
// Depends on acm_pkg, acm_seq and affine_cipher_mod26_assert.svh.
module affine_cipher_mod26 (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input acm_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output acm_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import acm_pkg::*;

	`include "affine_cipher_mod26_assert.svh"

	logic [4:0] key_mult_q;
	logic [4:0] key_add_q;
	logic [4:0] inv_q;
	logic known_q;
	in_t item_q;
	logic [9:0] acc_q;
	logic [4:0] r_prev_q;
	logic [4:0] r_cur_q;
	logic signed [6:0] t_prev_q;
	logic signed [6:0] t_cur_q;
	logic out_valid_q;
	out_t out_q;

	ctl_t ctl;
	pc_t pc;
	logic ctl_fire;
	stat_t st;

	logic cfg_wr;
	logic [4:0] a_r;
	logic [4:0] b_r;
	in_t src;
	logic [4:0] x;
	logic [5:0] d_raw;
	logic [4:0] d;
	logic [4:0] op_a;
	logic [4:0] op_b;
	logic [9:0] acc_d;
	logic signed [6:0] t_fix;
	logic letter;
	logic err;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_KEY_ADD) ? {27'd0, key_add_q} : {27'd0, key_mult_q};

	assign a_r = (key_mult_q >= 5'(ALPHA)) ? key_mult_q - 5'(ALPHA) : key_mult_q;
	assign b_r = (key_add_q >= 5'(ALPHA)) ? key_add_q - 5'(ALPHA) : key_add_q;

	assign st.in_valid = in_valid;
	assign st.out_busy = out_valid_q && out_stall;
	assign st.need_inv = in_data.cmd && !known_q;
	assign st.a_zero = (a_r == 5'd0);
	assign st.sub_ge = (r_prev_q >= r_cur_q);
	assign st.rprev_nz = (r_prev_q != 5'd0);

	acm_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.st(st),
		.ctl(ctl),
		.pc(pc),
		.fire(ctl_fire)
	);

	assign in_stall = (pc != PC_FETCH);

	always_comb begin
		src = (pc == PC_FETCH) ? in_data : item_q;
		x = 5'(src.in_char - LETTER_A);
		d_raw = {1'b0, x} + 6'(ALPHA) - {1'b0, b_r};
		d = (d_raw >= 6'(ALPHA)) ? 5'(d_raw - 6'(ALPHA)) : 5'(d_raw);
		op_a = src.cmd ? inv_q : a_r;
		op_b = src.cmd ? d : x;
		acc_d = 10'({5'd0, op_a} * {5'd0, op_b}) + (src.cmd ? 10'd0 : {5'd0, b_r});
		t_fix = (t_prev_q < 0) ? t_prev_q + 7'sd26 : t_prev_q;
		letter = (item_q.in_char >= LETTER_A) && (item_q.in_char < LETTER_A + 8'(ALPHA));
		err = item_q.cmd && (inv_q == 5'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mult_q <= KEY_MULT_RESET;
			key_add_q <= KEY_ADD_RESET;
			inv_q <= 5'd0;
			known_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_KEY_ADD) begin
					key_add_q <= pwdata[4:0];
				end else begin
					key_mult_q <= pwdata[4:0];
				end
				known_q <= 1'b0;
			end else if (ctl_fire && ctl.inv_wr) begin
				inv_q <= (r_prev_q == 5'd1) ? 5'(t_fix) : 5'd0;
				known_q <= 1'b1;
			end
			if (ctl_fire && ctl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_fire && ctl.ld_item) begin
			item_q <= in_data;
		end
		if (ctl_fire && ctl.ld_acc) begin
			acc_q <= acc_d;
		end
		if (ctl_fire && ctl.euc_init) begin
			r_prev_q <= 5'(ALPHA);
			r_cur_q <= a_r;
			t_prev_q <= 7'sd0;
			t_cur_q <= 7'sd1;
		end else if (ctl_fire && ctl.euc_sub && st.sub_ge) begin
			r_prev_q <= r_prev_q - r_cur_q;
			t_prev_q <= t_prev_q - t_cur_q;
		end else if (ctl_fire && ctl.euc_swap) begin
			r_prev_q <= r_cur_q;
			r_cur_q <= r_prev_q;
			t_prev_q <= t_cur_q;
			t_cur_q <= t_prev_q;
		end
		if (ctl_fire && ctl.ld_out) begin
			out_q.key_error <= err;
			out_q.out_char <= (letter && !err) ? 8'(acm_mod26(acc_q)) + LETTER_A : item_q.in_char;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`ACM_ASSERT_IMP(a_inv_ok, known_q && (inv_q != 5'd0), acm_mod26(10'({5'd0, a_r} * {5'd0, inv_q})) == 5'd1)
	`ACM_ASSERT_IMP(a_sub_nz, pc == PC_ESUB, r_cur_q != 5'd0)
	`ACM_ASSERT_NXT(a_emit, (pc == PC_EMIT) && ctl_fire, out_valid_q)
	`ACM_ASSERT_IMP(a_err, out_valid_q && out_q.key_error, known_q && (inv_q == 5'd0))

endmodule

// ===== hdl/acm_seq.sv =====
// Microcode sequencer for the affine cipher: step counter, control ROM and jump logic.
// Depends on acm_pkg for the control word, status bundle and ROM contents.
module acm_seq (
	input logic clk,
	input logic arst_n,
	input acm_pkg::stat_t st,
	output acm_pkg::ctl_t ctl,
	output acm_pkg::pc_t pc,
	output logic fire
);
	import acm_pkg::*;

	pc_t pc_q;
	logic hold_act;
	logic taken;

	assign pc = pc_q;
	assign ctl = acm_rom(pc_q);

	always_comb begin
		case (ctl.hold)
			HOLD_NO_IN: hold_act = !st.in_valid;
			HOLD_OUT_BUSY: hold_act = st.out_busy;
			default: hold_act = 1'b0;
		endcase
		case (ctl.jc)
			J_ALWAYS: taken = 1'b1;
			J_NEED_INV: taken = st.need_inv;
			J_A_ZERO: taken = st.a_zero;
			J_SUB_GE: taken = st.sub_ge;
			J_RPREV_NZ: taken = st.rprev_nz;
			default: taken = 1'b0;
		endcase
	end

	assign fire = !hold_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else if (!hold_act) begin
			pc_q <= taken ? ctl.jmp : ctl.nxt;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for affine_cipher_mod26: encrypt and decrypt items against a predictor.
// Covers key writes and readback over APB and random stalls on both channels.
// Depends on acm_pkg and the affine_cipher_mod26 RTL.
`timescale 1ns / 100ps

module testbench;
	import acm_pkg::*;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;
	localparam int IDLE_PCT = 36;
	localparam int LATENCY_WAIT = 48;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	in_t pending_chars[$];
	out_t expected_chars[$];
	out_t want_char;
	logic [4:0] key_mult_q = KEY_MULT_RESET;
	logic [4:0] key_add_q = KEY_ADD_RESET;
	logic [4:0] inv_value = 5'd0;
	logic inv_known = 1'b0;
	logic steady = 1'b0;
	int error_count = 0;
	int cycle_count = 0;

	affine_cipher_mod26 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	function automatic out_t cipher_predict(input in_t item);
		out_t r;
		int mult;
		int add;
		int x;
		logic letter;
		mult = int'(key_mult_q) % ALPHA;
		add = int'(key_add_q) % ALPHA;
		letter = (item.in_char >= LETTER_A) && (item.in_char < LETTER_A + 8'd26);
		x = int'(item.in_char) - int'(LETTER_A);
		r.out_char = item.in_char;
		r.key_error = 1'b0;
		if (item.cmd == CMD_ENCRYPT) begin
			if (letter) begin
				r.out_char = 8'((mult * x + add) % ALPHA) + LETTER_A;
			end
		end else begin
			if (!inv_known) begin
				inv_value = 5'd0;
				for (int t = 1; t < ALPHA; t++) begin
					if ((mult * t) % ALPHA == 1) begin
						inv_value = 5'(t);
					end
				end
				inv_known = 1'b1;
			end
			if (inv_value == 5'd0) begin
				r.key_error = 1'b1;
			end else if (letter) begin
				r.out_char = 8'((int'(inv_value) * ((x + ALPHA - add) % ALPHA)) % ALPHA)
					+ LETTER_A;
			end
		end
		return r;
	endfunction

	// Writes one key register with random upper bits, then reads it back.
	task automatic set_key(input logic reg_idx, input logic [4:0] value);
		logic [31:0] word;
		word = ($urandom() & ~32'h1F) | 32'(value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_idx == REG_KEY_MULT) begin
			key_mult_q = value;
		end else begin
			key_add_q = value;
		end
		inv_known = 1'b0;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[4:0] !== value) begin
			note_error($sformatf("readback reg %0d expected %0d got %0d", reg_idx, value,
				prdata[4:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_item(input logic cmd, input logic [7:0] ch);
		in_t item;
		item.cmd = cmd;
		item.in_char = ch;
		pending_chars.push_back(item);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_chars.size() != 0 || in_valid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY_WAIT) @(negedge clk);
	endtask

	// Mostly letters, with arbitrary bytes mixed in.
	task automatic run_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 70) begin
				queue_item(1'($urandom_range(1)), LETTER_A + 8'($urandom_range(25)));
			end else begin
				queue_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_chars.push_back(cipher_predict(in_data));
			end
			if (!in_valid || !in_stall) begin
				if (pending_chars.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_data <= pending_chars.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					note_error($sformatf("unexpected item out_char=%02h key_error=%0b",
						out_data.out_char, out_data.key_error));
				end else begin
					want_char = expected_chars.pop_front();
					if (out_data.out_char !== want_char.out_char
							|| out_data.key_error !== want_char.key_error) begin
						note_error($sformatf("out_char exp %02h got %02h, key_error exp %0b got %0b",
							want_char.out_char, out_data.out_char, want_char.key_error,
							out_data.key_error));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [4:0] mult_list [6];
		logic [4:0] add_list [6];
		mult_list = '{5'd0, 5'd25, 5'd31, 5'd1, 5'd13, 5'd3};
		add_list = '{5'd0, 5'd25, 5'd31, 5'd0, 5'd7, 5'd26};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Keys straight from reset; the first item is a decrypt.
		queue_item(CMD_DECRYPT, LETTER_A);
		queue_item(CMD_DECRYPT, LETTER_A + 8'd25);
		queue_item(CMD_ENCRYPT, LETTER_A);
		queue_item(CMD_ENCRYPT, LETTER_A + 8'd25);
		queue_item(CMD_ENCRYPT, 8'h40);
		queue_item(CMD_ENCRYPT, 8'h5B);
		queue_item(CMD_DECRYPT, 8'h40);
		queue_item(CMD_DECRYPT, 8'h5B);
		queue_item(CMD_ENCRYPT, 8'h00);
		queue_item(CMD_DECRYPT, 8'hFF);
		queue_item(CMD_ENCRYPT, 8'h20);
		queue_item(CMD_DECRYPT, 8'h61);
		queue_item(CMD_ENCRYPT, 8'h7A);
		queue_item(CMD_DECRYPT, 8'h4D);
		wait_idle();

		// Keys with no inverse, including zero and 26, then 27, which reduces to 1 and has one.
		set_key(REG_KEY_MULT, 5'd13);
		queue_item(CMD_DECRYPT, LETTER_A);
		queue_item(CMD_DECRYPT, 8'h20);
		queue_item(CMD_ENCRYPT, 8'h4D);
		wait_idle();
		set_key(REG_KEY_ADD, 5'd25);
		set_key(REG_KEY_MULT, 5'd0);
		queue_item(CMD_DECRYPT, LETTER_A + 8'd25);
		queue_item(CMD_ENCRYPT, LETTER_A + 8'd25);
		wait_idle();
		set_key(REG_KEY_MULT, 5'd26);
		queue_item(CMD_ENCRYPT, 8'h51);
		queue_item(CMD_DECRYPT, 8'h51);
		wait_idle();
		set_key(REG_KEY_MULT, 5'd27);
		queue_item(CMD_DECRYPT, 8'h51);
		queue_item(CMD_ENCRYPT, 8'h51);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			set_key(REG_KEY_MULT, mult_list[p]);
			set_key(REG_KEY_ADD, add_list[p]);
			run_phase(80);
		end

		// A long stretch with no idling on either side.
		steady = 1'b1;
		set_key(REG_KEY_MULT, 5'($urandom_range(31)));
		set_key(REG_KEY_ADD, 5'($urandom_range(31)));
		run_phase(150);
		steady = 1'b0;

		for (int p = 0; p < 6; p++) begin
			if ($urandom_range(1) == 0) begin
				set_key(REG_KEY_MULT, 5'($urandom_range(31)));
			end
			set_key(REG_KEY_ADD, 5'($urandom_range(31)));
			run_phase(80);
		end

		if (expected_chars.size() != 0) begin
			note_error($sformatf("%0d items never came out", expected_chars.size()));
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
